// File: rtl/two_level_page_table_map_unmap_unit_defines.svh
// assertion macros for the page table map/unmap unit
// used by the port checker; no other dependencies
`ifndef TWO_LEVEL_PAGE_TABLE_MAP_UNMAP_UNIT_DEFINES_SVH
`define TWO_LEVEL_PAGE_TABLE_MAP_UNMAP_UNIT_DEFINES_SVH

// generic clocked assertion with asynchronous active-low reset
`define TLPT_ASSERT(lbl, ck, rn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// assertion on the block clock and reset
`define TLPT_CHECK(lbl, prop, msg) \
	`TLPT_ASSERT(lbl, clk, arst_n, prop, msg)

`endif

// File: rtl/tlpt_pkg.sv
// shared types and constants for the page table map/unmap unit
// no dependencies
`default_nettype none

package tlpt_pkg;

	localparam int IDX_W       = 10;
	localparam int PAGE_SHIFT  = 12;
	localparam int FRAME_W     = 20;
	localparam int VADDR_W     = 32;
	localparam int FLAGS_W     = 12;
	localparam int CHANGED_W   = 21;
	localparam int STATUS_W    = 2;
	localparam int ENTRY_W     = 32;

	// stream word layout
	localparam int IN_TDATA_W  = 112;
	localparam int OUT_TDATA_W = 24;

	localparam logic CMD_MAP   = 1'b0;
	localparam logic CMD_UNMAP = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 2'd0,
		ST_ALREADY    = 2'd1,
		ST_NOT_MAPPED = 2'd2
	} status_t;

	// start of an index reduction
	typedef struct packed {
		logic             start;
		logic [IDX_W-1:0] value;
	} mod_req_t;

endpackage

`default_nettype wire

// File: rtl/tlpt_idx_mod.sv
// reduces a 10-bit address index modulo a constant by reciprocal multiplication
// depends on tlpt_pkg; the remainder is registered on start
`default_nettype none

module tlpt_idx_mod #(
	parameter int MODULUS = 1024,
	parameter int RES_W   = 10
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire tlpt_pkg::mod_req_t req,
	output logic [RES_W-1:0]        result
);
	import tlpt_pkg::*;

	// (value * RECIP) >> RECIP_SHIFT is the exact quotient for any 10-bit value
	localparam int RECIP_SHIFT = 2 * IDX_W;
	localparam int RECIP_W     = RECIP_SHIFT + 1;
	localparam int PROD_W      = IDX_W + RECIP_W;
	localparam int RECIP       = ((1 << RECIP_SHIFT) + MODULUS - 1) / MODULUS;

	logic [PROD_W-1:0] prod;
	logic [IDX_W-1:0]  quot;
	logic [PROD_W-1:0] quot_mul;
	logic [IDX_W-1:0]  rem;
	logic [RES_W-1:0]  rem_q;

	assign prod     = PROD_W'(req.value) * PROD_W'(RECIP);
	assign quot     = prod[RECIP_SHIFT +: IDX_W];
	assign quot_mul = PROD_W'(quot) * PROD_W'(MODULUS);
	assign rem      = req.value - quot_mul[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (req.start) begin
			rem_q <= rem[RES_W-1:0];
		end
	end

	assign result = rem_q;

endmodule

`default_nettype wire

// File: rtl/two_level_page_table_map_unmap_unit.sv
// top level of the two-level page table map/unmap unit
// depends on tlpt_pkg and tlpt_idx_mod
`default_nettype none

// Keeps the directory present bits in one synchronous memory of DIR_ENTRIES
// bits and all page entries in a second synchronous memory of DIR_ENTRIES *
// TABLE_ENTRIES words, both read through a registered port. After reset the
// directory is swept to zero one slot a cycle, so s_axis_tready stays low until
// the sweep is done. Each request maps or unmaps the 4 KiB pages from the
// aligned-down start up to below start + length (end clamped at 4 GiB) and
// returns one response with a status and the number of entries written.
// Requests are handled one at a time: a request is accepted, then the
// reduced start indexes are taken, then for each page walked both memories
// are read and the entry is checked and written back; a walk that runs to its
// end adds the range check that stops it. For every directory slot that a map
// has to create, the new table is swept to zero one entry a cycle, then the
// page is read again. Last the response is posted, held back only while the
// previous response still waits on m_axis_tready.
// A new request is taken as soon as the previous one has posted its
// response, even while that response still waits on m_axis_tready.
// Entries are only read for a check after their table has been swept.
module two_level_page_table_map_unmap_unit #(
	parameter int DIR_ENTRIES   = 1024,
	parameter int TABLE_ENTRIES = 1024
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	// request stream
	input  wire                                 s_axis_tvalid,
	output logic                                s_axis_tready,
	// virtual start, physical start, length, flags, remap enable, 3 zero bits
	input  wire  [tlpt_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// cmd
	input  wire                                 s_axis_tuser,
	// response stream
	output logic                                m_axis_tvalid,
	input  wire                                 m_axis_tready,
	// status, pages_changed, 1 zero bit
	output logic [tlpt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
	import tlpt_pkg::*;

	localparam int DMOD_W    = $clog2(DIR_ENTRIES);
	localparam int TMOD_W    = $clog2(TABLE_ENTRIES);
	localparam int MEM_DEPTH = DIR_ENTRIES * TABLE_ENTRIES;
	localparam int MEM_AW    = $clog2(MEM_DEPTH);
	localparam int PAGE_W    = FRAME_W + 1;     // page number up to 2^20
	localparam int END_W     = VADDR_W + 1;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_MOD,
		S_WALK,
		S_CLEAR,
		S_READ,
		S_DONE
	} state_t;

	// request field unpacking
	logic               in_cmd;
	logic [VADDR_W-1:0] in_virt;
	logic [VADDR_W-1:0] in_phys;
	logic [VADDR_W-1:0] in_len;
	logic [FLAGS_W-1:0] in_flags;
	logic               in_remap;

	assign in_cmd   = s_axis_tuser;
	assign in_virt  = s_axis_tdata[31:0];
	assign in_phys  = s_axis_tdata[63:32];
	assign in_len   = s_axis_tdata[95:64];
	assign in_flags = s_axis_tdata[107:96];
	assign in_remap = s_axis_tdata[108];

	// request registers
	state_t              state_q;
	logic                cmd_q;
	logic [PAGE_W-1:0]   va_q;        // current page number
	logic [END_W-1:0]    end_q;       // exclusive end byte address
	logic [FRAME_W-1:0]  phys_q;      // next frame number
	logic [FLAGS_W-1:0]  flags_q;
	logic                remap_q;
	logic [CHANGED_W-1:0] changed_q;
	status_t             status_q;
	logic [DMOD_W-1:0]   dmod_q;      // directory slot of current page
	logic [TMOD_W-1:0]   tmod_q;      // table slot of current page
	logic [TMOD_W-1:0]   clr_q;       // sweep position while clearing a table
	logic [DMOD_W-1:0]   init_q;      // sweep position of the directory after reset
	logic                m_valid_q;
	logic [OUT_TDATA_W-1:0] m_data_q;

	// directory memory
	logic                dir_mem [DIR_ENTRIES];
	logic                dir_rd_q;

	// entry memory
	logic [ENTRY_W-1:0]  entry_mem [MEM_DEPTH];
	logic [ENTRY_W-1:0]  rdata_q;

	logic               accept;
	logic [END_W-1:0]   end_sum;
	logic [END_W-1:0]   end_clamp;
	logic               in_range;
	logic               dir_hit;
	logic               rd_present;
	logic               read_fail;
	logic               clr_last;
	logic [DMOD_W-1:0]  dir_addr;
	logic               dir_we;
	logic               dir_re;
	logic               dir_wdata;
	logic [TMOD_W-1:0]  mem_tidx;
	logic [MEM_AW-1:0]  mem_addr;
	logic               mem_we;
	logic               mem_re;
	logic [ENTRY_W-1:0] mem_wdata;
	logic [TMOD_W-1:0]  tmod_nx;
	logic [DMOD_W-1:0]  dmod_nx;
	logic               out_free;

	// start index reduction
	mod_req_t           dmod_req;
	mod_req_t           tmod_req;
	logic [DMOD_W-1:0]  dmod_res;
	logic [TMOD_W-1:0]  tmod_res;

	assign accept        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE);

	// end address in 33 bits, clamped to the top of the address space
	assign end_sum   = {1'b0, in_virt} + {1'b0, in_len};
	assign end_clamp = end_sum[VADDR_W] ? {1'b1, {VADDR_W{1'b0}}} : end_sum;

	assign in_range   = {va_q, {PAGE_SHIFT{1'b0}}} < end_q;
	assign dir_hit    = dir_rd_q;
	assign rd_present = rdata_q[0];
	assign read_fail  = (cmd_q == CMD_MAP) ? (rd_present && !remap_q) : !rd_present;
	assign clr_last   = (clr_q == TMOD_W'(TABLE_ENTRIES - 1));

	assign dmod_req = '{start: accept, value: in_virt[31:22]};
	assign tmod_req = '{start: accept, value: in_virt[21:12]};

	tlpt_idx_mod #(
		.MODULUS (DIR_ENTRIES),
		.RES_W   (DMOD_W)
	) u_dir_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dmod_req),
		.result (dmod_res)
	);

	tlpt_idx_mod #(
		.MODULUS (TABLE_ENTRIES),
		.RES_W   (TMOD_W)
	) u_tab_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (tmod_req),
		.result (tmod_res)
	);

	// slots of the next page: a table field wrap carries into the directory field
	always_comb begin
		tmod_nx = tmod_q;
		dmod_nx = dmod_q;
		if (va_q[IDX_W-1:0] == {IDX_W{1'b1}}) begin
			tmod_nx = '0;
			dmod_nx = (dmod_q == DMOD_W'(DIR_ENTRIES - 1)) ? '0 : dmod_q + DMOD_W'(1);
		end else begin
			tmod_nx = (tmod_q == TMOD_W'(TABLE_ENTRIES - 1)) ? '0 : tmod_q + TMOD_W'(1);
		end
	end

	// directory port: reset sweep, slot creation at the end of a table sweep,
	// read together with the page entry
	assign dir_addr  = (state_q == S_INIT) ? init_q : dmod_q;
	assign dir_we    = (state_q == S_INIT) || ((state_q == S_CLEAR) && clr_last);
	assign dir_wdata = (state_q == S_CLEAR);
	assign dir_re    = (state_q == S_WALK) && in_range;

	always_ff @(posedge clk) begin
		if (dir_we) begin
			dir_mem[dir_addr] <= dir_wdata;
		end
		if (dir_re) begin
			dir_rd_q <= dir_mem[dir_addr];
		end
	end

	// entry port: sweep address while clearing, else the current page;
	// the entry read is ignored when the directory slot turns out absent
	assign mem_tidx  = (state_q == S_CLEAR) ? clr_q : tmod_q;
	assign mem_addr  = MEM_AW'(MEM_AW'(dmod_q) * MEM_AW'(TABLE_ENTRIES)) + MEM_AW'(mem_tidx);
	assign mem_re    = (state_q == S_WALK) && in_range;
	assign mem_we    = (state_q == S_CLEAR) || ((state_q == S_READ) && dir_hit && !read_fail);
	assign mem_wdata = ((state_q == S_READ) && (cmd_q == CMD_MAP)) ?
		{phys_q, flags_q | FLAGS_W'(1)} : '0;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			entry_mem[mem_addr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= entry_mem[mem_addr];
		end
	end

	assign out_free = !m_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_INIT;
			cmd_q         <= CMD_MAP;
			va_q          <= '0;
			end_q         <= '0;
			phys_q        <= '0;
			flags_q       <= '0;
			remap_q       <= 1'b0;
			changed_q     <= '0;
			status_q      <= ST_OK;
			dmod_q        <= '0;
			tmod_q        <= '0;
			clr_q         <= '0;
			init_q        <= '0;
			m_valid_q     <= 1'b0;
			m_data_q      <= '0;
		end else begin
			// response leaves on tready; a new one is only posted from S_DONE
			if ((state_q != S_DONE) && m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				S_INIT: begin
					// all directory slots absent before the first request
					if (init_q == DMOD_W'(DIR_ENTRIES - 1)) begin
						state_q <= S_IDLE;
					end else begin
						init_q <= init_q + DMOD_W'(1);
					end
				end
				S_IDLE: begin
					if (accept) begin
						cmd_q     <= in_cmd;
						va_q      <= {1'b0, in_virt[VADDR_W-1:PAGE_SHIFT]};
						end_q     <= end_clamp;
						phys_q    <= in_phys[VADDR_W-1:PAGE_SHIFT];
						flags_q   <= in_flags;
						remap_q   <= in_remap;
						changed_q <= '0;
						status_q  <= ST_OK;
						state_q   <= S_MOD;
					end
				end
				S_MOD: begin
					// reducers registered their results at the accept edge
					dmod_q  <= dmod_res;
					tmod_q  <= tmod_res;
					state_q <= S_WALK;
				end
				S_WALK: begin
					if (!in_range) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_READ;
					end
				end
				S_CLEAR: begin
					// fresh table: zero every entry, then mark the slot present
					if (clr_last) begin
						state_q <= S_WALK;
					end else begin
						clr_q <= clr_q + TMOD_W'(1);
					end
				end
				S_READ: begin
					if (!dir_hit) begin
						if (cmd_q == CMD_MAP) begin
							clr_q   <= '0;
							state_q <= S_CLEAR;
						end else begin
							status_q <= ST_NOT_MAPPED;
							state_q  <= S_DONE;
						end
					end else if (read_fail) begin
						status_q <= (cmd_q == CMD_MAP) ? ST_ALREADY : ST_NOT_MAPPED;
						state_q  <= S_DONE;
					end else begin
						if (cmd_q == CMD_MAP) begin
							phys_q <= phys_q + FRAME_W'(1);
						end
						changed_q <= changed_q + CHANGED_W'(1);
						va_q      <= va_q + PAGE_W'(1);
						tmod_q    <= tmod_nx;
						dmod_q    <= dmod_nx;
						state_q   <= S_WALK;
					end
				end
				S_DONE: begin
					if (out_free) begin
						m_valid_q <= 1'b1;
						m_data_q  <= {1'b0, changed_q, status_q};
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule

`default_nettype wire

// File: rtl/tlpt_port_checker.sv
// port-level checks for the page table map/unmap unit, bound to the top level
// depends on tlpt_pkg and two_level_page_table_map_unmap_unit_defines.svh
`default_nettype none

`include "two_level_page_table_map_unmap_unit_defines.svh"

module tlpt_port_checker (
	input wire                              clk,
	input wire                              arst_n,
	input wire                              s_axis_tvalid,
	input wire                              s_axis_tready,
	input wire                              m_axis_tvalid,
	input wire                              m_axis_tready,
	input wire [tlpt_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
	import tlpt_pkg::*;

	logic [STATUS_W-1:0]  rsp_status;
	logic [CHANGED_W-1:0] rsp_changed;

	assign rsp_status  = m_axis_tdata[1:0];
	assign rsp_changed = m_axis_tdata[22:2];

	// a stalled response holds its contents
	`TLPT_CHECK(a_rsp_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "response changed while stalled")

	// one request in flight: no back-to-back request acceptance
	`TLPT_CHECK(a_one_in_flight, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "request accepted while another is in progress")

	// only defined status codes leave the block
	`TLPT_CHECK(a_status_code, m_axis_tvalid |-> rsp_status == ST_OK || rsp_status == ST_ALREADY || rsp_status == ST_NOT_MAPPED, "undefined status code")

	// never more pages than the address space holds
	`TLPT_CHECK(a_changed_max, m_axis_tvalid |-> rsp_changed <= 21'h100000 && !m_axis_tdata[23], "page count out of range")

endmodule

bind two_level_page_table_map_unmap_unit tlpt_port_checker u_port_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// File: dv/two_level_page_table_map_unmap_unit_checker.sv
// request/response layout and the checker for the page table map/unmap unit
// depends on tlpt_pkg; watches both streams, predicts each response and compares
package tlpt_tb_pkg;
	import tlpt_pkg::*;

	// request, lowest bits first: cmd (tuser), then tdata: virt, phys, length,
	// flags, remap, pad
	typedef struct packed {
		logic [2:0]          pad;
		logic                remap;
		logic [FLAGS_W-1:0]  flags;
		logic [31:0]         length;
		logic [31:0]         phys;
		logic [VADDR_W-1:0]  virt;
		logic                cmd;
	} map_req_t;

	// response word, lowest bits first: status, pages_changed, pad
	typedef struct packed {
		logic                 pad;
		logic [CHANGED_W-1:0] changed;
		status_t              status;
	} map_resp_t;
endpackage

module two_level_page_table_map_unmap_unit_checker #(
	parameter int DIR_ENTRIES   = 1024,
	parameter int TABLE_ENTRIES = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	input  logic                             s_axis_tready,
	input  logic [tlpt_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	input  logic                             s_axis_tuser,
	input  logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	input  logic [tlpt_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	output int                               errors,
	output int                               pending
);
	import tlpt_pkg::*;
	import tlpt_tb_pkg::*;

	localparam logic [31:0] PAGE_MASK = 32'hFFFF_F000;
	localparam logic [32:0] ADDR_TOP  = 33'h1_0000_0000;

	logic                dir_valid [DIR_ENTRIES];
	bit [ENTRY_W-1:0]    entry_store [int unsigned];
	map_resp_t           resp_q [$];
	int                  fail_cnt;
	map_req_t            seen_req;
	map_resp_t           seen_resp;
	map_resp_t           want_resp;

	function automatic bit entry_present(int unsigned slot);
		return entry_store.exists(slot) && entry_store[slot][0];
	endfunction

	// walks the pages of one request, updates the shadow table, returns the response
	function automatic map_resp_t walk_request(map_req_t rq);
		logic [32:0]  stop_at;
		logic [32:0]  va;
		logic [31:0]  frame;
		int unsigned  dslot;
		int unsigned  eslot;
		map_resp_t    r;
		stop_at = {1'b0, rq.virt} + {1'b0, rq.length};
		if (stop_at > ADDR_TOP)
			stop_at = ADDR_TOP;
		va = {1'b0, rq.virt & PAGE_MASK};
		frame = rq.phys & PAGE_MASK;
		r = '0;
		r.status = ST_OK;
		while (va < stop_at) begin
			dslot = int'(va[31:22]) % DIR_ENTRIES;
			eslot = dslot * TABLE_ENTRIES + int'(va[21:12]) % TABLE_ENTRIES;
			if (rq.cmd == CMD_MAP) begin
				if (!dir_valid[dslot]) begin
					for (int t = 0; t < TABLE_ENTRIES; t++)
						entry_store.delete(dslot * TABLE_ENTRIES + t);
					dir_valid[dslot] = 1'b1;
				end
				if (entry_present(eslot) && !rq.remap) begin
					r.status = ST_ALREADY;
					break;
				end
				entry_store[eslot] = frame | {20'd0, rq.flags} | 32'd1;
				frame = frame + 32'h1000;
			end else begin
				if (!dir_valid[dslot] || !entry_present(eslot)) begin
					r.status = ST_NOT_MAPPED;
					break;
				end
				entry_store[eslot] = '0;
			end
			r.changed = r.changed + 1'b1;
			va = va + 33'h1000;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (dir_valid[i])
				dir_valid[i] = 1'b0;
			entry_store.delete();
			resp_q.delete();
			fail_cnt = 0;
			errors <= 0;
			pending <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				seen_resp = m_axis_tdata;
				if (resp_q.size() == 0) begin
					$error("response with no request waiting: status %0d pages_changed %0d",
						seen_resp.status, seen_resp.changed);
					fail_cnt++;
				end else begin
					want_resp = resp_q.pop_front();
					if (seen_resp.status !== want_resp.status) begin
						$error("status: expected %0d, got %0d", want_resp.status,
							seen_resp.status);
						fail_cnt++;
					end
					if (seen_resp.changed !== want_resp.changed) begin
						$error("pages_changed: expected %0d, got %0d", want_resp.changed,
							seen_resp.changed);
						fail_cnt++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				seen_req = {s_axis_tdata, s_axis_tuser};
				resp_q.push_back(walk_request(seen_req));
			end
			errors <= fail_cnt;
			pending <= resp_q.size();
		end
	end

endmodule

// File: dv/two_level_page_table_map_unmap_unit_tb.sv
// top of the page table map/unmap unit testbench: clock, reset, stimulus, verdict
// depends on tlpt_pkg, tlpt_tb_pkg and the checker module
module two_level_page_table_map_unmap_unit_tb;
	import tlpt_pkg::*;
	import tlpt_tb_pkg::*;

	// cycles with no request or response moving before the run is called hung;
	// the worst request creates two tables, each swept entry by entry
	localparam int QUIET_LIMIT   = 20000;
	localparam int RAND_PER_PASS = 145;
	localparam int DRAIN_CYCLES  = 64;
	localparam int HOT_SLOTS     = 6;

	logic                     clk;
	logic                     arst_n = 1'b0;
	logic                     s_axis_tvalid = 1'b0;
	logic                     s_axis_tready;
	// virtual start, physical start, length, flags, remap enable, 3 zero bits
	logic [IN_TDATA_W-1:0]    s_axis_tdata = '0;
	// cmd
	logic                     s_axis_tuser = 1'b0;
	logic                     m_axis_tvalid;
	logic                     m_axis_tready = 1'b0;
	// status, pages_changed, 1 zero bit
	logic [OUT_TDATA_W-1:0]   m_axis_tdata;

	int                       fail_total;
	int                       req_pending;
	int                       idle_pct = 0;
	int                       stall_pct = 0;
	int                       quiet_cycles = 0;

	// directory slots that most random requests land in, so maps and unmaps meet
	logic [IDX_W-1:0]         hot_slot [HOT_SLOTS];
	// ranges mapped recently, reused for unmap and remap requests
	logic [31:0]              recent_virt [$];
	logic [31:0]              recent_len [$];

	two_level_page_table_map_unmap_unit DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	two_level_page_table_map_unmap_unit_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.errors        (fail_total),
		.pending       (req_pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// response side: stall at the rate of the current pass
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= stall_pct);
	end

	// watchdog on cycles where neither stream moves
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	function automatic map_req_t make_req(logic cmd, logic [31:0] virt, logic [31:0] phys,
		logic [31:0] len, logic [FLAGS_W-1:0] flg, logic remap);
		map_req_t rq;
		rq = '0;
		rq.cmd = cmd;
		rq.virt = virt;
		rq.phys = phys;
		rq.length = len;
		rq.flags = flg;
		rq.remap = remap;
		return rq;
	endfunction

	// one request on the slave side, with random idle cycles ahead of it;
	// tvalid stays high straight into the next request when no gap is drawn
	task automatic send_map_req(input map_req_t rq);
		while ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		{s_axis_tdata, s_axis_tuser} <= rq;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// mostly well-formed traffic: fresh maps in hot slots, unmaps and remaps of
	// earlier ranges; the rest is noise with full-range addresses or lengths
	task automatic send_random_req();
		int unsigned  pick;
		int unsigned  k;
		int unsigned  npages;
		map_req_t     rq;
		pick = $urandom_range(99);
		rq = make_req(CMD_MAP, 32'd0, $urandom, 32'd0, FLAGS_W'($urandom_range(4095)),
			$urandom_range(99) < 30);
		if (pick < 40 || (pick < 75 && recent_virt.size() == 0)) begin
			// fresh short range, partial first page included
			npages = $urandom_range(1, 8);
			rq.virt = {hot_slot[$urandom_range(HOT_SLOTS - 1)], IDX_W'($urandom_range(1023)),
				12'($urandom_range(4095))};
			rq.length = $urandom_range(1, npages * 4096);
			if (recent_virt.size() < 48) begin
				recent_virt.push_back(rq.virt);
				recent_len.push_back(rq.length);
			end
		end else if (pick < 75) begin
			k = $urandom_range(recent_virt.size() - 1);
			rq.virt = recent_virt[k];
			rq.length = recent_len[k];
			if (pick < 65) begin
				rq.cmd = CMD_UNMAP;
				recent_virt.delete(k);
				recent_len.delete(k);
			end
		end else begin
			case ($urandom_range(3))
				0: begin
					// anywhere in the address space, may create new tables
					rq.cmd = 1'($urandom_range(1));
					rq.virt = $urandom;
					rq.length = $urandom_range(0, 32'h3000);
				end
				1: begin
					// long unmap in a busy slot, stops at the first hole
					rq.cmd = CMD_UNMAP;
					rq.virt = {hot_slot[$urandom_range(HOT_SLOTS - 1)], 22'($urandom)};
					rq.length = $urandom;
				end
				2: begin
					// near the top, end clamped at 4 GiB keeps the walk short
					rq.cmd = 1'($urandom_range(1));
					rq.virt = 32'hFFFF_FFFF - $urandom_range(0, 32'h7FFF);
					rq.length = $urandom;
				end
				default: begin
					rq.cmd = CMD_UNMAP;
					rq.virt = $urandom;
					rq.length = $urandom;
				end
			endcase
		end
		send_map_req(rq);
	endtask

	initial begin : stimulus
		foreach (hot_slot[i])
			hot_slot[i] = IDX_W'($urandom_range(1, 1022));
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, no idling
		// unmap where no table exists yet
		send_map_req(make_req(CMD_UNMAP, 32'h0040_0000, 32'h0, 32'h1000, 12'h0, 1'b0));
		// aligned start with zero length walks nothing
		send_map_req(make_req(CMD_MAP, 32'h0040_0000, 32'h0, 32'h0, 12'h0, 1'b0));
		// zero length, unaligned start: the page holding the start is mapped
		send_map_req(make_req(CMD_MAP, 32'h0040_0800, 32'hFFFF_FFFF, 32'h0, 12'hFFF, 1'b0));
		// overlap on the first page without remap
		send_map_req(make_req(CMD_MAP, 32'h0040_0FFF, 32'h1234_5000, 32'h2001, 12'h0, 1'b0));
		// same range with remap, physical frame wraps past 4 GiB
		send_map_req(make_req(CMD_MAP, 32'h0040_0FFF, 32'hFFFF_E000, 32'h2001, 12'h0, 1'b1));
		// starts in a new table below, then crosses into the next table and hits a present page
		send_map_req(make_req(CMD_MAP, 32'h003F_E000, 32'h0ABC_D000, 32'h3000, 12'h555, 1'b0));
		// unmap runs into a page that is not present
		send_map_req(make_req(CMD_UNMAP, 32'h0040_0000, 32'h0, 32'h5000, 12'h0, 1'b0));
		send_map_req(make_req(CMD_UNMAP, 32'h003F_E000, 32'h0, 32'h2000, 12'h0, 1'b0));
		// table present but page already cleared
		send_map_req(make_req(CMD_UNMAP, 32'h003F_E000, 32'h0, 32'h2000, 12'h0, 1'b0));
		// end beyond 4 GiB is clamped
		send_map_req(make_req(CMD_MAP, 32'hFFFF_E800, 32'h1234_5678, 32'hFFFF_FFFF,
			12'hAAA, 1'b0));
		send_map_req(make_req(CMD_MAP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			12'hFFF, 1'b1));
		send_map_req(make_req(CMD_UNMAP, 32'hFFFF_E000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			12'hFFF, 1'b1));
		// flags with bit zero clear still give a present entry
		send_map_req(make_req(CMD_MAP, 32'h0000_0000, 32'h0000_0FFF, 32'h1, 12'h0, 1'b0));
		send_map_req(make_req(CMD_MAP, 32'h0000_0000, 32'h0000_0000, 32'h1000, 12'h1, 1'b0));
		send_map_req(make_req(CMD_UNMAP, 32'h0000_0000, 32'h0, 32'hFFFF_FFFF, 12'h0, 1'b0));
		// map, remap and unmap of a longer run
		send_map_req(make_req(CMD_MAP, 32'h8000_0000, 32'h5555_5000, 32'h10000, 12'h2AA, 1'b0));
		send_map_req(make_req(CMD_MAP, 32'h8000_4000, 32'hAAAA_A000, 32'h2000, 12'hF0F, 1'b1));
		send_map_req(make_req(CMD_UNMAP, 32'h8000_0000, 32'h0, 32'h10000, 12'h0, 1'b0));

		// random part in passes: no idling, sender idle, receiver stall, both
		for (int pass = 0; pass < 4; pass++) begin
			case (pass)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 69; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 69; end
				default: begin idle_pct = 17; stall_pct = 17; end
			endcase
			repeat (RAND_PER_PASS)
				send_random_req();
		end
		s_axis_tvalid <= 1'b0;

		// drain: the watchdog catches responses that never come
		do @(posedge clk); while (req_pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_total == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+rtl
rtl/tlpt_pkg.sv
rtl/tlpt_idx_mod.sv
rtl/two_level_page_table_map_unmap_unit.sv
rtl/tlpt_port_checker.sv
dv/two_level_page_table_map_unmap_unit_checker.sv
dv/two_level_page_table_map_unmap_unit_tb.sv
